FILE: hdl/dpr_pkg.sv
// shared types and constants for the disparity reprojector
`timescale 1ns / 1ps
package dpr_pkg;
  localparam int MaxColsDefault = 4096;
  localparam int MaxRowsDefault = 4096;
  localparam int WW = 53;
  localparam logic [30:0] MaxDepthReset = 31'd655360000;

  typedef enum logic [2:0] {
    REG_FOCAL = 3'd0, REG_OFFX = 3'd1, REG_OFFY = 3'd2, REG_INVB = 3'd3,
    REG_WOFF = 3'd4, REG_MAXD = 3'd5, REG_CMODE = 3'd6, REG_NONE = 3'd7
  } reg_idx_t;

  localparam logic [1:0] ModeMono = 2'd0;
  localparam logic [1:0] ModeBgr = 2'd1;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic signed [15:0] disparity;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0] point_z;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;
endpackage

FILE: hdl/disparity_to_point_reprojector.sv
// top level: disparity pixel to 3-d point reprojection pipeline
// throughput: one pixel per cycle while in_stall is low
// every stage, the 55 divider stages too, is pipelined
// a point blocked at the output parks in a one-entry skid register; in_stall is its flag
// reset (synchronous, rst_n low) clears valid bits and sets config registers to their reset values
`timescale 1ns / 1ps
module disparity_to_point_reprojector
  import dpr_pkg::*;
#(
  parameter int MAX_COLS = MaxColsDefault,
  parameter int MAX_ROWS = MaxRowsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  dpr_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output dpr_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int NW = 55;
  localparam int TWZ = 1 + 24;

  // configuration registers
  logic signed [31:0] focal_r, offx_r, offy_r, invb_r, woff_r;
  logic [30:0] maxd_r;
  logic [1:0] cmode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= '0; offx_r <= '0; offy_r <= '0; invb_r <= '0; woff_r <= '0;
      maxd_r <= MaxDepthReset; cmode_r <= ModeMono;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FOCAL: focal_r <= cfg_data;
        REG_OFFX:  offx_r <= cfg_data;
        REG_OFFY:  offy_r <= cfg_data;
        REG_INVB:  invb_r <= cfg_data;
        REG_WOFF:  woff_r <= cfg_data;
        REG_MAXD:  maxd_r <= cfg_data[30:0];
        REG_CMODE: cmode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // global enable: the pipeline advances unless the skid register is occupied
  logic en;
  logic skid_v_r;
  assign en = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage 1: clamp coordinates, multiply disparity by gain, colour select
  logic v1_r;
  logic signed [47:0] dprod_r;
  logic [11:0] col1_r, row1_r;
  logic [23:0] rgb1_r;
  logic [11:0] colc, rowc;
  logic [23:0] rgb;

  always_comb begin
    colc = in_data.col;
    rowc = in_data.row;
    if ({20'd0, in_data.col} >= 32'(MAX_COLS)) colc = 12'(MAX_COLS - 1);
    if ({20'd0, in_data.row} >= 32'(MAX_ROWS)) rowc = 12'(MAX_ROWS - 1);
    case (cmode_r)
      ModeMono: rgb = {in_data.chan0, in_data.chan0, in_data.chan0};
      ModeBgr:  rgb = {in_data.chan2, in_data.chan1, in_data.chan0};
      default:  rgb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid && (in_data.disparity != 16'sd0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dprod_r <= in_data.disparity * invb_r;
      col1_r <= colc; row1_r <= rowc; rgb1_r <= rgb;
    end
  end

  // stage 2: w, numerators, signs and magnitudes
  logic v2_r;
  logic [WW-1:0] w2_r;
  logic [NW-1:0] nz2_r, nx2_r, ny2_r;
  logic sx2_r, sy2_r, sz2_r;
  logic [23:0] rgb2_r;
  logic signed [WW-1:0] w_s;
  logic signed [33:0] xn, yn;
  logic signed [NW-1:0] zf, xf, yf;

  always_comb begin
    w_s = WW'(dprod_r) + (WW'(woff_r) <<< 4);
    xn = 34'({col1_r, 16'd0}) + 34'(offx_r);
    yn = 34'({row1_r, 16'd0}) + 34'(offy_r);
    zf = NW'(focal_r) <<< 20;
    xf = NW'(xn) <<< 20;
    yf = NW'(yn) <<< 20;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r && !w_s[WW-1] && (w_s != '0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      w2_r <= w_s;
      sz2_r <= zf[NW-1]; sx2_r <= xf[NW-1]; sy2_r <= yf[NW-1];
      nz2_r <= zf[NW-1] ? -zf : zf;
      nx2_r <= xf[NW-1] ? -xf : xf;
      ny2_r <= yf[NW-1] ? -yf : yf;
      rgb2_r <= rgb1_r;
    end
  end

  // three divider pipelines; each tag carries its sign, the z tag also the colour
  logic [NW-1:0] qz, qx, qy;
  logic [TWZ-1:0] tz;
  logic tx_s, ty_s;

  dpr_div #(.NW(NW), .DW(WW), .TW(TWZ)) u_div_z (
    .clk(clk), .en(en), .num(nz2_r), .den(w2_r),
    .tag_in({sz2_r, rgb2_r}), .quo(qz), .tag_out(tz));
  dpr_div #(.NW(NW), .DW(WW), .TW(1)) u_div_x (
    .clk(clk), .en(en), .num(nx2_r), .den(w2_r),
    .tag_in(sx2_r), .quo(qx), .tag_out(tx_s));
  dpr_div #(.NW(NW), .DW(WW), .TW(1)) u_div_y (
    .clk(clk), .en(en), .num(ny2_r), .den(w2_r),
    .tag_in(sy2_r), .quo(qy), .tag_out(ty_s));

  // valid that travels with the divider data, reset-cleared
  logic [NW-1:0] vpipe_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vpipe_r <= '0;
    else if (en) vpipe_r <= {vpipe_r[NW-2:0], v2_r};
  end

  // stage 3: sign restore, saturation, depth window
  function automatic logic signed [31:0] sat32(input logic [NW-1:0] mag, input logic neg);
    logic signed [NW:0] v;
    v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (v > 56'sd2147483647) return 32'sh7fffffff;
    if (v < -56'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [31:0] zs, xs, ys;
  logic keep;
  out_item_t pt_new;
  always_comb begin
    zs = sat32(qz, tz[TWZ-1]);
    xs = sat32(qx, tx_s);
    ys = sat32(qy, ty_s);
    keep = vpipe_r[NW-1] && (zs > 32'sd0) && (zs < $signed({1'b0, maxd_r}));
    pt_new.point_x = xs;
    pt_new.point_y = ys;
    pt_new.point_z = zs[30:0];
    {pt_new.red, pt_new.green, pt_new.blue} = tz[23:0];
  end

  // output register plus one-entry skid register
  out_item_t skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!skid_v_r) begin
      if (!out_valid || !out_stall) out_valid <= keep;
      else if (keep) skid_v_r <= 1'b1;
    end else if (!out_stall) begin
      // skid point moves up, out_valid stays high
      skid_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      if (!out_valid || !out_stall) out_data <= pt_new;
      else skid_r <= pt_new;
    end else if (!out_stall) begin
      out_data <= skid_r;
    end
  end
endmodule

FILE: hdl/dpr_div.sv
// pipelined restoring divider, one quotient bit per stage, unsigned
`timescale 1ns / 1ps
module dpr_div #(
  parameter int NW = 55,
  parameter int DW = 53,
  parameter int TW = 8
) (
  input  logic clk,
  input  logic en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  logic [NW-1:0] q_r [1:NW];
  logic [DW:0] rem_r [1:NW-1];
  logic [DW-1:0] d_r [1:NW-1];
  logic [TW-1:0] t_r [1:NW];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [NW-1:0] q_in;
    logic [DW:0] rem_in;
    logic [DW-1:0] d_in;
    logic [TW-1:0] t_in;
    logic [DW+1:0] trial;
    logic [DW:0] rem_nxt;
    logic [NW-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign q_in = num;
      assign rem_in = '0;
      assign d_in = den;
      assign t_in = tag_in;
    end else begin : g_next
      assign q_in = q_r[s];
      assign rem_in = rem_r[s];
      assign d_in = d_r[s];
      assign t_in = t_r[s];
    end

    always_comb begin
      trial = {rem_in, q_in[NW-1-s]} - {1'b0, 1'b0, d_in};
      q_nxt = q_in;
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        q_nxt[NW-1-s] = 1'b1;
      end else begin
        rem_nxt = {rem_in[DW-1:0], q_in[NW-1-s]};
        q_nxt[NW-1-s] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1] <= q_nxt;
        t_r[s+1] <= t_in;
      end
    end

    if (s < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_nxt;
          d_r[s+1] <= d_in;
        end
      end
    end
  end

  assign quo = q_r[NW];
  assign tag_out = t_r[NW];
endmodule

FILE: hdl/dpr_checker.sv
// port-level checker for the reprojector, bound to the top level
`timescale 1ns / 1ps
module dpr_checker
  import dpr_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input dpr_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no point waiting");
  a_z_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.point_z != '0)
    else $error("zero depth emitted");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind disparity_to_point_reprojector dpr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_data(out_data));

FILE: tb/sv/tb.sv
// testbench for the disparity-to-point reprojector: directed table, random pixels, scoreboard
`timescale 1ns / 1ps
module tb;
  import dpr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  disparity_to_point_reprojector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the register file
  logic signed [31:0] focal_q, offx_q, offy_q, invb_q, woff_q;
  logic [30:0] maxd_q;
  logic [1:0] cmode_q;

  out_item_t points_pending[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_out = 1'b0;   // long receiver hold-off request
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_len = 0;
  int rx_wait = 0;

  localparam int PipeLatency = 60;
  localparam longint CycleLimit = 200000;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // truncating quotient of (num * 2^20) / den, saturated to 32 bits
  function automatic logic signed [31:0] sat_quot(input longint num, input longint den);
    logic signed [127:0] n, q;
    n = 128'(signed'(num)) * 128'sd1048576;
    q = n / 128'(signed'(den));
    if (q > 128'sd2147483647) return 32'sh7fffffff;
    if (q < -128'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  // compute the point for one pixel; returns 0 when the pixel drops out
  function automatic bit project_pixel(input in_item_t px, output out_item_t pt);
    longint c, r, d, w;
    logic signed [31:0] z;
    pt = '0;
    c = px.col;
    r = px.row;
    d = px.disparity;
    if (d == 0) return 0;
    w = d * longint'(invb_q) + longint'(woff_q) * 16;
    if (w <= 0) return 0;
    z = sat_quot(focal_q, w);
    if (z <= 0 || z >= $signed({1'b0, maxd_q})) return 0;
    pt.point_x = sat_quot(c * 65536 + longint'(offx_q), w);
    pt.point_y = sat_quot(r * 65536 + longint'(offy_q), w);
    pt.point_z = z[30:0];
    case (cmode_q)
      ModeMono: begin pt.red = px.chan0; pt.green = px.chan0; pt.blue = px.chan0; end
      ModeBgr: begin pt.red = px.chan2; pt.green = px.chan1; pt.blue = px.chan0; end
      default: begin pt.red = 8'd0; pt.green = 8'd0; pt.blue = 8'd0; end
    endcase
    return 1;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FOCAL: focal_q = val;
      REG_OFFX: offx_q = val;
      REG_OFFY: offy_q = val;
      REG_INVB: invb_q = val;
      REG_WOFF: woff_q = val;
      REG_MAXD: maxd_q = val[30:0];
      REG_CMODE: cmode_q = val[1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] fl, ox, oy, ib, wo, md, cm);
    write_reg(REG_FOCAL, fl);
    write_reg(REG_OFFX, ox);
    write_reg(REG_OFFY, oy);
    write_reg(REG_INVB, ib);
    write_reg(REG_WOFF, wo);
    write_reg(REG_MAXD, md);
    write_reg(REG_CMODE, cm);
    cfg_valid <= 1'b0;
  endtask

  // wait for the block to drain, then the pipeline depth for dropped pixels
  task automatic drain();
    while (points_pending.size() != 0) @(posedge clk);
    repeat (PipeLatency + 10) @(posedge clk);
  endtask

  // send one pixel after a random gap; expectation queued at acceptance
  task automatic send_pixel(input in_item_t px);
    out_item_t pt;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    if (project_pixel(px, pt)) points_pending.insert(points_pending.size(), pt);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  // directed rows: pixel plus optional known result of whether it emits a point
  typedef struct {
    in_item_t px;
    bit has_known;
    bit known_emits;
  } pixel_row_t;

  function automatic in_item_t mk(input int c, r, d, input int b0, b1, b2);
    in_item_t p;
    p.col = 12'(c); p.row = 12'(r); p.disparity = 16'(d);
    p.chan0 = 8'(b0); p.chan1 = 8'(b1); p.chan2 = 8'(b2);
    return p;
  endfunction

  function automatic in_item_t rand_pixel();
    in_item_t p;
    p = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) p.disparity = 16'sd0;
    return p;
  endfunction

  // receiver: a random wait per point, plus long hold-off when asked
  always @(posedge clk) begin
    int draw;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_stall <= 1'b1;
      rx_wait <= 0;
    end else if (out_valid && !out_stall) begin
      draw = $urandom_range(0, 9);
      rx_wait <= draw;
      out_stall <= hold_out || (draw != 0);
    end else if (hold_out) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long hold counted here
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_len <= 300;
    end else if (hold_len > 0) begin
      hold_out <= 1'b1;
      hold_len <= hold_len - 1;
    end else begin
      hold_out <= 1'b0;
    end
  end

  // checker
  always @(posedge clk) begin
    out_item_t exp_pt;
    if (rst_n && out_valid && !out_stall) begin
      if (points_pending.size() == 0) begin
        report("point with no pixel waiting");
      end else begin
        exp_pt = points_pending.pop_front();
        if (out_data.point_x !== exp_pt.point_x)
          report($sformatf("x got %0d want %0d", out_data.point_x, exp_pt.point_x));
        if (out_data.point_y !== exp_pt.point_y)
          report($sformatf("y got %0d want %0d", out_data.point_y, exp_pt.point_y));
        if (out_data.point_z !== exp_pt.point_z)
          report($sformatf("z got %0d want %0d", out_data.point_z, exp_pt.point_z));
        if (out_data.red !== exp_pt.red) report("red");
        if (out_data.green !== exp_pt.green) report("green");
        if (out_data.blue !== exp_pt.blue) report("blue");
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  pixel_row_t dir_rows[$];

  initial begin
    pixel_row_t row_e;
    out_item_t pt;
    bit got;
    focal_q = 0; offx_q = 0; offy_q = 0; invb_q = 0; woff_q = 0;
    maxd_q = MaxDepthReset; cmode_q = ModeMono;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset every w is zero, so nothing comes out
    row_e.px = mk(5, 7, 100, 1, 2, 3); row_e.has_known = 1; row_e.known_emits = 0;
    dir_rows.insert(dir_rows.size(), row_e);
    foreach (dir_rows[i]) begin
      got = project_pixel(dir_rows[i].px, pt);
      if (dir_rows[i].has_known && got != dir_rows[i].known_emits) report("reset row");
      send_pixel(dir_rows[i].px);
    end
    idle_input();
    drain();

    // typical camera: f=500, baseline gain 65536, mono
    write_all(32'd500 << 16, -(32'd320 << 16), -(32'd240 << 16),
              32'd65536 / 16 * 16, 32'd0, MaxDepthReset, ModeMono);
    dir_rows.delete();
    row_e.has_known = 0;
    row_e.px = mk(0, 0, 1, 255, 0, 0);                   // tiny disparity
    dir_rows.insert(dir_rows.size(), row_e);
    row_e.px = mk(4095, 4095, 32767, 0, 255, 255);       // extremes
    dir_rows.insert(dir_rows.size(), row_e);
    row_e.px = mk(100, 200, 0, 9, 9, 9);                 // zero disparity
    dir_rows.insert(dir_rows.size(), row_e);
    row_e.px = mk(100, 200, -32768, 9, 9, 9);            // w negative
    dir_rows.insert(dir_rows.size(), row_e);
    row_e.px = mk(320, 240, 16, 128, 64, 32);
    dir_rows.insert(dir_rows.size(), row_e);
    row_e.px = mk(4095, 0, 2, 170, 85, 1);
    dir_rows.insert(dir_rows.size(), row_e);
    foreach (dir_rows[i]) send_pixel(dir_rows[i].px);
    idle_input();
    drain();

    // bgr, tiny w for saturation of x and y, small depth limit
    write_all(32'd1, 32'h7fffffff, 32'h80000000, 32'd1, 32'd0, 32'd2, ModeBgr);
    send_pixel(mk(4095, 4095, 1, 1, 2, 3));
    send_pixel(mk(0, 0, 1, 4, 5, 6));
    idle_input();
    drain();
    // black mode, w from a gain of -1 plus the offset, max depth at top
    write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'd65536,
              32'h7fffffff, 2'd3);
    send_pixel(mk(12, 34, 1, 200, 100, 50));
    send_pixel(mk(12, 34, -1, 200, 100, 50));
    send_pixel(mk(4095, 4095, -32768, 255, 255, 255));
    idle_input();
    drain();

    // random phases with differing settings
    for (int ph = 0; ph < 6; ph++) begin
      write_all(($urandom_range(1, 2000)) << 16,
                ph[0] ? $urandom : -($urandom_range(0, 4000) << 16),
                ph[1] ? $urandom : -($urandom_range(0, 4000) << 16),
                ph == 5 ? $urandom : $urandom_range(1, 1 << 17),
                ph == 4 ? $urandom : $urandom_range(0, 1 << 16),
                ph == 3 ? $urandom_range(0, 1 << 20) : 32'h7fffffff,
                ph % 3);
      if (ph == 2) hold_go <= 1'b1; // fill the pipeline while output is held
      for (int k = 0; k < 180; k++) send_pixel(rand_pixel());
      idle_input();
      drain();   // sender pause until every point is back
    end

    idle_input();
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
